/* rtl/core/altmw_pkg.sv */
// shared types and character constants for the assembly line to machine word block
package altmw_pkg;

   // widths of the result word
   localparam int WORD_W = 16;

   // characters the parser and encoder react to
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_BANG  = 8'h21;
   localparam logic [7:0] CHAR_AMP   = 8'h26;
   localparam logic [7:0] CHAR_LPAR  = 8'h28;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_ONE   = 8'h31;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_EQ    = 8'h3D;
   localparam logic [7:0] CHAR_AT    = 8'h40;
   localparam logic [7:0] CHAR_A     = 8'h41;
   localparam logic [7:0] CHAR_D     = 8'h44;
   localparam logic [7:0] CHAR_M     = 8'h4D;
   localparam logic [7:0] CHAR_BAR   = 8'h7C;

   // comment tracking within a line
   typedef enum logic [1:0] {
      COM_NORMAL = 2'd0,
      COM_SLASH  = 2'd1,
      COM_INSIDE = 2'd2
   } comment_mode_type;

   // three byte text buffer, entry 0 is the first byte
   typedef logic [2:0][7:0] text_type;

   // everything gathered about the current line
   typedef struct packed {
      comment_mode_type comment_mode;
      logic             at_seen;
      logic             digits_open;
      logic [15:0]      address_value;
      logic             paren_seen;
      logic             equals_seen;
      logic             semicolon_seen;
      logic             comp_closed;
      text_type         first_text;
      logic [2:0]       first_count;
      text_type         comp_text;
      logic [1:0]       comp_count;
      text_type         jump_text;
      logic [1:0]       jump_count;
   } line_type;

   // encoded outcome of a finished line
   typedef struct packed {
      logic              hit;
      logic [WORD_W-1:0] word;
      logic              is_address;
   } result_type;

endpackage

/* rtl/core/assembly_line_to_machine_word.sv */
// top level: assembles one text line into one machine word
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | req_character, req_end_of_text
//   rsp     | out       | rsp_valid/rsp_stall | rsp_instruction_word, rsp_is_address
//
// one character per cycle while req_stall is low; once the newline or final byte is taken,
// its word passes the input register, then parser and table lookup into the result register
// synchronous active-high reset empties the line state and both registers
// a held result does not block the input register from filling; input stalls only
// when the input register is full and the result register is held by rsp_stall
module assembly_line_to_machine_word (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_character,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_instruction_word,
   output logic        rsp_is_address
);
   import altmw_pkg::*;

   logic              in_valid_ff;
   logic              in_valid_in;
   logic [7:0]        in_char_ff;
   logic              in_eot_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [WORD_W-1:0] rsp_word_ff;
   logic              rsp_addr_ff;
   logic              out_free;
   logic              step;
   logic              take_req;
   logic              line_end;
   line_type          line_done;
   result_type        result;

   // flow control
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign take_req  = req_valid && !req_stall;

   assign in_valid_in  = take_req ? 1'b1 : (step ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = (step && line_end && result.hit) ? 1'b1 : (rsp_valid_ff && rsp_stall);

   // input register
   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else in_valid_ff <= in_valid_in;
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         in_char_ff <= req_character;
         in_eot_ff  <= req_end_of_text;
      end
   end

   altmw_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .character   (in_char_ff),
      .end_of_text (in_eot_ff),
      .line_end    (line_end),
      .line_done   (line_done)
   );

   altmw_encoder u_encoder (
      .line_done (line_done),
      .result    (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (step && line_end && result.hit) begin
         rsp_word_ff <= result.word;
         rsp_addr_ff <= result.is_address;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_instruction_word = rsp_word_ff;
   assign rsp_is_address       = rsp_addr_ff;

   // a waiting input transaction is never dropped
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !step |=> in_valid_ff)
      else $error("input transaction lost while waiting");

   // a finished line with a word always reaches the result register
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      step && line_end && result.hit |=> rsp_valid_ff)
      else $error("finished line did not produce a result");

   // compute words carry the fixed prefix
   a_compute_prefix: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_addr_ff |-> rsp_word_ff[15:13] == 3'b111)
      else $error("compute word without prefix");

   // a new result only follows a processed line end
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(step && line_end))
      else $error("result without a line end");

endmodule

/* rtl/core/altmw_parser.sv */
// per-character line parser holding the state of the open line
module altmw_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          character,
   input  logic                end_of_text,
   output logic                line_end,
   output altmw_pkg::line_type line_done
);
   import altmw_pkg::*;

   line_type state_ff;
   line_type state_in;

   // empty line state
   function automatic line_type clear_line();
      line_type r;
      r = '0;
      r.comment_mode = COM_NORMAL;
      return r;
   endfunction

   // bytes allowed in a compute field after the equals sign
   function automatic logic is_comp_char(input logic [7:0] c);
      return c == CHAR_A || c == CHAR_M || c == CHAR_D || c == CHAR_ZERO ||
             c == CHAR_ONE || c == CHAR_MINUS || c == CHAR_PLUS || c == CHAR_BANG ||
             c == CHAR_AMP || c == CHAR_BAR;
   endfunction

   // one significant byte into the line state
   function automatic line_type take_char(input line_type s, input logic [7:0] c);
      line_type r;
      r = s;
      if (c == CHAR_SPACE || c == CHAR_TAB) begin
         r = s;
      end else if (c == CHAR_AT) begin
         if (!s.at_seen) begin
            r.at_seen     = 1'b1;
            r.digits_open = 1'b1;
         end else begin
            r.digits_open = 1'b0;
         end
      end else if (s.at_seen && s.digits_open && c >= CHAR_ZERO && c <= CHAR_NINE) begin
         // times ten plus digit, wrapping at 16 bits
         r.address_value = {s.address_value[12:0], 3'b000} +
                           {s.address_value[14:0], 1'b0} + {12'd0, c[3:0]};
      end else begin
         if (s.at_seen && s.digits_open) begin
            r.digits_open = 1'b0;
         end
         if (c == CHAR_LPAR) begin
            r.paren_seen = 1'b1;
         end
         if (c == CHAR_EQ && !s.equals_seen && !s.semicolon_seen) begin
            r.equals_seen = 1'b1;
         end else if (c == CHAR_SEMI && !s.semicolon_seen) begin
            r.semicolon_seen = 1'b1;
            r.comp_closed    = 1'b1;
         end else if (s.semicolon_seen) begin
            if (s.jump_count < 2'd3) begin
               r.jump_text[s.jump_count] = c;
               r.jump_count              = s.jump_count + 2'd1;
            end
         end else if (s.equals_seen) begin
            if (!s.comp_closed && s.comp_count < 2'd3 && is_comp_char(c)) begin
               r.comp_text[s.comp_count] = c;
               r.comp_count              = s.comp_count + 2'd1;
            end else begin
               r.comp_closed = 1'b1;
            end
         end else if (s.first_count < 3'd3) begin
            r.first_text[s.first_count[1:0]] = c;
            r.first_count                    = s.first_count + 3'd1;
         end else begin
            r.first_count = 3'd4;
         end
      end
      return r;
   endfunction

   // next line state for the byte in hand
   always_comb begin
      line_type s;
      logic     is_break;
      s        = state_ff;
      is_break = character == CHAR_LF || character == CHAR_CR;
      if (!is_break) begin
         case (state_ff.comment_mode)
            COM_NORMAL: begin
               if (character == CHAR_SLASH) s.comment_mode = COM_SLASH;
               else s = take_char(s, character);
            end
            COM_SLASH: begin
               if (character == CHAR_SLASH) begin
                  s.comment_mode = COM_INSIDE;
               end else begin
                  // lone slash counts as an ordinary byte
                  s.comment_mode = COM_NORMAL;
                  s = take_char(take_char(s, CHAR_SLASH), character);
               end
            end
            default: begin
               s = state_ff;
            end
         endcase
      end
      line_end = step && (character == CHAR_LF || end_of_text);
      // slash still pending when the line closes
      if (s.comment_mode == COM_SLASH && (character == CHAR_LF || end_of_text)) begin
         s = take_char(s, CHAR_SLASH);
      end
      line_done = s;
      if (!step) state_in = state_ff;
      else if (line_end) state_in = clear_line();
      else state_in = s;
   end

   // line state register
   always_ff @(posedge clock) begin
      if (reset) state_ff <= clear_line();
      else state_ff <= state_in;
   end

endmodule

/* rtl/core/altmw_encoder.sv */
// turns a finished line into an address or compute word
module altmw_encoder (
   input  altmw_pkg::line_type   line_done,
   output altmw_pkg::result_type result
);
   import altmw_pkg::*;

   // compute table, returns hit and six bit code
   function automatic logic [6:0] comp_lookup(input logic [2:0] len, input text_type t);
      logic [6:0] r;
      case ({len, t[0], t[1], t[2]})
         {3'd1, "0", 16'h0000}: r = {1'b1, 6'h2A};
         {3'd1, "1", 16'h0000}: r = {1'b1, 6'h3F};
         {3'd2, "-1", 8'h00}:   r = {1'b1, 6'h3A};
         {3'd1, "D", 16'h0000}: r = {1'b1, 6'h0C};
         {3'd1, "A", 16'h0000}: r = {1'b1, 6'h30};
         {3'd2, "!D", 8'h00}:   r = {1'b1, 6'h0D};
         {3'd2, "!A", 8'h00}:   r = {1'b1, 6'h31};
         {3'd2, "-D", 8'h00}:   r = {1'b1, 6'h0F};
         {3'd2, "-A", 8'h00}:   r = {1'b1, 6'h33};
         {3'd3, "D+1"}:         r = {1'b1, 6'h1F};
         {3'd3, "A+1"}:         r = {1'b1, 6'h37};
         {3'd3, "D-1"}:         r = {1'b1, 6'h0E};
         {3'd3, "A-1"}:         r = {1'b1, 6'h32};
         {3'd3, "D+A"}:         r = {1'b1, 6'h02};
         {3'd3, "D-A"}:         r = {1'b1, 6'h13};
         {3'd3, "A-D"}:         r = {1'b1, 6'h07};
         {3'd3, "D&A"}:         r = {1'b1, 6'h00};
         {3'd3, "D|A"}:         r = {1'b1, 6'h15};
         default:               r = 7'd0;
      endcase
      return r;
   endfunction

   // destination table, unknown gives zero
   function automatic logic [2:0] dest_lookup(input logic [2:0] len, input text_type t);
      logic [2:0] r;
      case ({len, t[0], t[1], t[2]})
         {3'd1, "M", 16'h0000}: r = 3'd1;
         {3'd1, "D", 16'h0000}: r = 3'd2;
         {3'd2, "MD", 8'h00}:   r = 3'd3;
         {3'd1, "A", 16'h0000}: r = 3'd4;
         {3'd2, "AM", 8'h00}:   r = 3'd5;
         {3'd2, "AD", 8'h00}:   r = 3'd6;
         {3'd3, "AMD"}:         r = 3'd7;
         default:               r = 3'd0;
      endcase
      return r;
   endfunction

   // jump table, unknown gives zero
   function automatic logic [2:0] jump_lookup(input logic [1:0] len, input text_type t);
      logic [2:0] r;
      case ({len, t[0], t[1], t[2]})
         {2'd3, "JGT"}: r = 3'd1;
         {2'd3, "JEQ"}: r = 3'd2;
         {2'd3, "JGE"}: r = 3'd3;
         {2'd3, "JLT"}: r = 3'd4;
         {2'd3, "JNE"}: r = 3'd5;
         {2'd3, "JLE"}: r = 3'd6;
         {2'd3, "JMP"}: r = 3'd7;
         default:       r = 3'd0;
      endcase
      return r;
   endfunction

   // field selection and table lookups
   always_comb begin
      text_type   txt;
      logic [2:0] len;
      logic       abit;
      logic [6:0] comp_hit;
      logic [6:0] comp_code;
      logic [2:0] dest_code;
      logic [2:0] jump_code;
      if (line_done.equals_seen) begin
         txt       = line_done.comp_text;
         len       = {1'b0, line_done.comp_count};
         dest_code = dest_lookup(line_done.first_count, line_done.first_text);
      end else begin
         txt       = line_done.first_text;
         len       = line_done.first_count;
         dest_code = 3'd0;
      end
      // first M reads as A and sets the a bit
      abit = 1'b1;
      if (txt[0] == CHAR_M) txt[0] = CHAR_A;
      else if (txt[1] == CHAR_M) txt[1] = CHAR_A;
      else if (txt[2] == CHAR_M) txt[2] = CHAR_A;
      else abit = 1'b0;
      comp_hit  = comp_lookup(len, txt);
      comp_code = comp_hit[6] ? {abit, comp_hit[5:0]} : 7'd0;
      jump_code = line_done.semicolon_seen ?
                  jump_lookup(line_done.jump_count, line_done.jump_text) : 3'd0;
      if (line_done.at_seen) begin
         result.hit        = 1'b1;
         result.word       = line_done.address_value;
         result.is_address = 1'b1;
      end else begin
         result.hit        = !line_done.paren_seen &&
                             (line_done.equals_seen || line_done.semicolon_seen);
         result.word       = {3'b111, comp_code, dest_code, jump_code};
         result.is_address = 1'b0;
      end
   end

endmodule

/* tb/altmw_word_checker.sv */
// checker: predicts machine words from accepted characters and compares them with the output
`timescale 1ns / 100ps
module altmw_word_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_character,
   input  logic        req_end_of_text,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [15:0] rsp_instruction_word,
   input  logic        rsp_is_address,
   output int          failures,
   output int          words_pending,
   output int          address_words,
   output int          compute_words
);
   import altmw_pkg::*;

   localparam logic [2:0] COMPUTE_PREFIX = 3'b111;

   // what has been gathered of the line now open
   line_type   cur;
   // machine words predicted but not yet seen at the output
   result_type word_queue[$];

   function automatic bit is_comp_symbol(input logic [7:0] c);
      return c == CHAR_A || c == CHAR_M || c == CHAR_D || c == CHAR_ZERO ||
             c == CHAR_ONE || c == CHAR_MINUS || c == CHAR_PLUS || c == CHAR_BANG ||
             c == CHAR_AMP || c == CHAR_BAR;
   endfunction

   // comp mnemonic to its six c bits, -1 when unknown
   function automatic int comp_code_of(input text_type t, input int len);
      if (len == 1) begin
         case (t[0])
            "0": return 6'h2A;
            "1": return 6'h3F;
            "D": return 6'h0C;
            "A": return 6'h30;
            default: ;
         endcase
      end
      if (len == 2) begin
         case ({t[0], t[1]})
            "-1": return 6'h3A;
            "!D": return 6'h0D;
            "!A": return 6'h31;
            "-D": return 6'h0F;
            "-A": return 6'h33;
            default: ;
         endcase
      end
      if (len == 3) begin
         case ({t[0], t[1], t[2]})
            "D+1": return 6'h1F;
            "A+1": return 6'h37;
            "D-1": return 6'h0E;
            "A-1": return 6'h32;
            "D+A": return 6'h02;
            "D-A": return 6'h13;
            "A-D": return 6'h07;
            "D&A": return 6'h00;
            "D|A": return 6'h15;
            default: ;
         endcase
      end
      return -1;
   endfunction

   // destination mnemonic to its three d bits, -1 when unknown
   function automatic int dest_code_of(input text_type t, input int len);
      if (len == 1) begin
         case (t[0])
            "M": return 1;
            "D": return 2;
            "A": return 4;
            default: ;
         endcase
      end
      if (len == 2) begin
         case ({t[0], t[1]})
            "MD": return 3;
            "AM": return 5;
            "AD": return 6;
            default: ;
         endcase
      end
      if (len == 3 && {t[0], t[1], t[2]} == "AMD")
         return 7;
      return -1;
   endfunction

   // jump mnemonic to its three j bits, -1 when unknown
   function automatic int jump_code_of(input text_type t, input int len);
      if (len == 3) begin
         case ({t[0], t[1], t[2]})
            "JGT": return 1;
            "JEQ": return 2;
            "JGE": return 3;
            "JLT": return 4;
            "JNE": return 5;
            "JLE": return 6;
            "JMP": return 7;
            default: ;
         endcase
      end
      return -1;
   endfunction

   // one character outside comments, blanks dropped here
   function automatic void absorb_char(input logic [7:0] c);
      if (c == CHAR_SPACE || c == CHAR_TAB)
         return;
      // first @ opens the digits, a later one closes them
      if (c == CHAR_AT) begin
         if (!cur.at_seen) begin
            cur.at_seen = 1'b1;
            cur.digits_open = 1'b1;
         end else begin
            cur.digits_open = 1'b0;
         end
         return;
      end
      if (cur.at_seen && cur.digits_open) begin
         if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            cur.address_value = 16'(cur.address_value * 16'd10 + 16'(c - CHAR_ZERO));
            return;
         end
         cur.digits_open = 1'b0;
      end
      if (c == CHAR_LPAR)
         cur.paren_seen = 1'b1;
      if (c == CHAR_EQ && !cur.equals_seen && !cur.semicolon_seen) begin
         cur.equals_seen = 1'b1;
         return;
      end
      if (c == CHAR_SEMI && !cur.semicolon_seen) begin
         cur.semicolon_seen = 1'b1;
         cur.comp_closed = 1'b1;
         return;
      end
      // jump field keeps its first three bytes
      if (cur.semicolon_seen) begin
         if (cur.jump_count < 3) begin
            cur.jump_text[cur.jump_count] = c;
            cur.jump_count = cur.jump_count + 2'd1;
         end
         return;
      end
      // comp field after = stops at the first byte outside its alphabet
      if (cur.equals_seen) begin
         if (!cur.comp_closed && cur.comp_count < 3 && is_comp_symbol(c)) begin
            cur.comp_text[cur.comp_count] = c;
            cur.comp_count = cur.comp_count + 2'd1;
         end else begin
            cur.comp_closed = 1'b1;
         end
         return;
      end
      // leading text, count 4 marks overflow
      if (cur.first_count < 3) begin
         cur.first_text[cur.first_count] = c;
         cur.first_count = cur.first_count + 3'd1;
      end else begin
         cur.first_count = 3'd4;
      end
   endfunction

   // word for the line just ended, hit low when the line gives nothing
   function automatic result_type encode_line();
      result_type r;
      text_type   txt;
      int         len;
      int         k;
      logic       abit;
      logic [6:0] cp;
      logic [2:0] dst;
      logic [2:0] jmp;
      r = '0;
      cp = '0;
      dst = '0;
      jmp = '0;
      abit = 1'b0;
      if (cur.at_seen) begin
         r.hit = 1'b1;
         r.word = cur.address_value;
         r.is_address = 1'b1;
      end else if (!cur.paren_seen && (cur.equals_seen || cur.semicolon_seen)) begin
         if (cur.equals_seen) begin
            k = dest_code_of(cur.first_text, cur.first_count);
            if (k > 0)
               dst = k[2:0];
            txt = cur.comp_text;
            len = cur.comp_count;
         end else begin
            txt = cur.first_text;
            len = cur.first_count;
         end
         // first M selects memory and reads as A
         if (len <= 3) begin
            for (int i = 0; i < len; i++) begin
               if (txt[i] == CHAR_M) begin
                  txt[i] = CHAR_A;
                  abit = 1'b1;
                  break;
               end
            end
            k = comp_code_of(txt, len);
            if (k >= 0)
               cp = {abit, k[5:0]};
         end
         if (cur.semicolon_seen) begin
            k = jump_code_of(cur.jump_text, cur.jump_count);
            if (k > 0)
               jmp = k[2:0];
         end
         r.hit = 1'b1;
         r.word = {COMPUTE_PREFIX, cp, dst, jmp};
         r.is_address = 1'b0;
      end
      return r;
   endfunction

   // one accepted character, with the comment filter in front of the parser
   function automatic result_type step_char(input logic [7:0] c, input logic eot);
      result_type r;
      r = '0;
      if (c != CHAR_LF && c != CHAR_CR) begin
         if (cur.comment_mode == COM_SLASH) begin
            if (c == CHAR_SLASH) begin
               cur.comment_mode = COM_INSIDE;
            end else begin
               cur.comment_mode = COM_NORMAL;
               absorb_char(CHAR_SLASH);
               absorb_char(c);
            end
         end else if (cur.comment_mode == COM_NORMAL) begin
            if (c == CHAR_SLASH)
               cur.comment_mode = COM_SLASH;
            else
               absorb_char(c);
         end
      end
      if (c == CHAR_LF || eot) begin
         // a slash left pending at the line end is an ordinary byte
         if (cur.comment_mode == COM_SLASH)
            absorb_char(CHAR_SLASH);
         r = encode_line();
         cur = '0;
      end
      return r;
   endfunction

   // predict on input transactions, compare on output transactions
   always @(posedge clock) begin : watch
      result_type r;
      result_type wanted;
      if (reset) begin
         cur = '0;
         word_queue.delete();
      end else begin
         if (req_valid && !req_stall) begin
            r = step_char(req_character, req_end_of_text);
            if (r.hit)
               word_queue.push_back(r);
         end
         if (rsp_valid && !rsp_stall) begin
            if (word_queue.size() == 0) begin
               failures++;
               $display("%0t: unexpected word, expected none got %h (address %b)",
                        $time, rsp_instruction_word, rsp_is_address);
            end else begin
               wanted = word_queue.pop_front();
               if (rsp_instruction_word !== wanted.word) begin
                  failures++;
                  $display("%0t: instruction word expected %h got %h",
                           $time, wanted.word, rsp_instruction_word);
               end
               if (rsp_is_address !== wanted.is_address) begin
                  failures++;
                  $display("%0t: address flag expected %b got %b",
                           $time, wanted.is_address, rsp_is_address);
               end
               if (wanted.is_address)
                  address_words++;
               else
                  compute_words++;
            end
         end
      end
      words_pending = word_queue.size();
   end

endmodule

/* tb/assembly_line_to_machine_word_tb.sv */
// testbench top: feeds assembly text under varied traffic and gives the verdict
`timescale 1ns / 100ps
module assembly_line_to_machine_word_tb;
   import altmw_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_character = 8'h00;
   logic        req_end_of_text = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_instruction_word;
   logic        rsp_is_address;

   int         failures;
   int         words_pending;
   int         address_words;
   int         compute_words;
   int         send_idle_pct = 0;
   int         stall_pct = 0;
   int         chars_sent = 0;
   bit         hold_req = 1'b0;
   logic [7:0] line_bytes[$];

   assembly_line_to_machine_word dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_character        (req_character),
      .req_end_of_text      (req_end_of_text),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_instruction_word (rsp_instruction_word),
      .rsp_is_address       (rsp_is_address)
   );

   altmw_word_checker word_check (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_character        (req_character),
      .req_end_of_text      (req_end_of_text),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_instruction_word (rsp_instruction_word),
      .rsp_is_address       (rsp_is_address),
      .failures             (failures),
      .words_pending        (words_pending),
      .address_words        (address_words),
      .compute_words        (compute_words)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // overall time limit
   initial begin
      #4_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // output side: random stalls, plus one long hold once asked for
   initial begin : output_side
      int hold_left;
      bit hold_taken;
      hold_left = 0;
      hold_taken = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   function automatic string comp_name(input int k);
      case (k)
         0: return "0";
         1: return "1";
         2: return "-1";
         3: return "D";
         4: return "A";
         5: return "!D";
         6: return "!A";
         7: return "-D";
         8: return "-A";
         9: return "D+1";
         10: return "A+1";
         11: return "D-1";
         12: return "A-1";
         13: return "D+A";
         14: return "D-A";
         15: return "A-D";
         16: return "D&A";
         17: return "D|A";
         default: return "A+D";
      endcase
   endfunction

   function automatic string dest_name(input int k);
      case (k)
         0: return "M";
         1: return "D";
         2: return "MD";
         3: return "A";
         4: return "AM";
         5: return "AD";
         6: return "AMD";
         default: return "DM";
      endcase
   endfunction

   function automatic string jump_name(input int k);
      case (k)
         0: return "JGT";
         1: return "JEQ";
         2: return "JGE";
         3: return "JLT";
         4: return "JNE";
         5: return "JLE";
         6: return "JMP";
         7: return "JXX";
         default: return "";
      endcase
   endfunction

   task automatic push_byte(input logic [7:0] c);
      line_bytes.push_back(c);
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++)
         line_bytes.push_back(s[i]);
   endtask

   // occasional space, tab or carriage return
   task automatic maybe_blank();
      case ($urandom_range(11))
         0: push_byte(CHAR_SPACE);
         1: push_byte(CHAR_TAB);
         2: push_byte(CHAR_CR);
         default: ;
      endcase
   endtask

   // one input transaction, with a random gap in front
   task automatic send_char(input logic [7:0] c, input logic eot);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_character <= c;
      req_end_of_text <= eot;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      chars_sent++;
   endtask

   task automatic send_line(input bit eot_last);
      for (int i = 0; i < line_bytes.size(); i++)
         send_char(line_bytes[i], eot_last && i == line_bytes.size() - 1);
      line_bytes.delete();
   endtask

   // dest=comp;jump with random parts, M forms and blanks between symbols
   task automatic build_compute();
      string s;
      bit    has_dest;
      bit    has_jump;
      bit    use_m;
      has_dest = ($urandom_range(9) < 7);
      has_jump = !has_dest || $urandom_range(2) == 0;
      if (has_dest) begin
         push_text(dest_name($urandom_range(7)));
         maybe_blank();
         push_byte(CHAR_EQ);
         maybe_blank();
      end
      s = comp_name($urandom_range(18));
      use_m = 1'($urandom_range(1));
      for (int i = 0; i < s.len(); i++) begin
         push_byte((use_m && s[i] == CHAR_A) ? CHAR_M : s[i]);
         maybe_blank();
      end
      if ($urandom_range(19) == 0)
         push_byte(CHAR_SLASH);
      if (has_jump) begin
         push_byte(CHAR_SEMI);
         maybe_blank();
         push_text(jump_name($urandom_range(8)));
      end
   endtask

   // one random line, sent with its ending
   task automatic random_line();
      int kind;
      int n;
      int ending;
      kind = $urandom_range(99);
      maybe_blank();
      if (kind < 25) begin
         // address, sometimes long enough to wrap, sometimes a second @ or junk
         push_byte(CHAR_AT);
         n = $urandom_range(7);
         for (int i = 0; i < n; i++)
            push_byte(8'(CHAR_ZERO + $urandom_range(9)));
         case ($urandom_range(7))
            0: begin
               push_byte(CHAR_AT);
               push_byte(8'(CHAR_ZERO + $urandom_range(9)));
            end
            1: push_text("D1");
            default: ;
         endcase
      end else if (kind < 65) begin
         build_compute();
      end else if (kind < 73) begin
         push_byte(CHAR_LPAR);
         push_text("LOOP");
         push_text(")");
      end else if (kind < 80) begin
         if ($urandom_range(1))
            push_text("// note");
      end else if (kind < 90) begin
         // well-formed line with one byte swapped for a mark or junk
         build_compute();
         n = $urandom_range(line_bytes.size() - 1);
         case ($urandom_range(7))
            0: line_bytes[n] = CHAR_EQ;
            1: line_bytes[n] = CHAR_SEMI;
            2: line_bytes[n] = CHAR_AT;
            3: line_bytes[n] = CHAR_LPAR;
            4: line_bytes[n] = CHAR_SLASH;
            5: line_bytes[n] = CHAR_M;
            6: line_bytes[n] = 8'(CHAR_ZERO + $urandom_range(9));
            default: line_bytes[n] = 8'($urandom_range(255));
         endcase
      end else begin
         n = 1 + $urandom_range(7);
         for (int i = 0; i < n; i++)
            push_byte(8'($urandom_range(255)));
      end
      // trailing comment or lone slash
      case ($urandom_range(19))
         0, 1, 2: begin
            push_text("//");
            n = $urandom_range(6);
            for (int i = 0; i < n; i++)
               push_byte(8'($urandom_range(126, 32)));
         end
         3: push_byte(CHAR_SLASH);
         default: ;
      endcase
      // line ends on newline, on the final byte flag, or both
      ending = $urandom_range(99);
      if (ending < 6) begin
         if (line_bytes.size() == 0)
            push_byte(CHAR_SPACE);
         send_line(1'b1);
      end else begin
         push_byte(CHAR_LF);
         send_line(ending < 10);
      end
   endtask

   task automatic run_phase(input int idle, input int stall, input int count);
      int target;
      send_idle_pct = idle;
      stall_pct = stall;
      target = chars_sent + count;
      while (chars_sent < target)
         random_line();
   endtask

   initial begin : stimulus
      int waited;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: wrapping address, memory compute with jump and comment, label,
      // extreme byte values ending on the final byte flag
      push_text("@99999");
      push_byte(CHAR_LF);
      send_line(1'b0);
      push_text("AM=M+1;JMP//");
      push_byte(CHAR_LF);
      send_line(1'b0);
      push_text("(L)");
      push_byte(CHAR_LF);
      send_line(1'b0);
      push_byte(8'hFF);
      push_byte(CHAR_NUL);
      send_line(1'b1);

      // random traffic under each idle and stall mix
      run_phase(0, 0, 140);
      run_phase(66, 0, 140);
      run_phase(0, 66, 140);
      run_phase(34, 34, 140);
      // long output hold while input keeps coming, so the block backs up
      hold_req = 1'b1;
      run_phase(0, 20, 140);

      req_valid <= 1'b0;
      stall_pct = 0;
      waited = 0;
      while (words_pending != 0 && waited < 5000) begin
         @(negedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);

      $display("covered %0d characters of addresses, computes, labels, comments and noise",
               chars_sent);
      $display("under five idle and stall mixes: %0d address and %0d compute words checked",
               address_words, compute_words);
      if (failures == 0 && words_pending == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

/* files.f */
rtl/core/altmw_pkg.sv
rtl/core/altmw_parser.sv
rtl/core/altmw_encoder.sv
rtl/core/assembly_line_to_machine_word.sv
tb/altmw_word_checker.sv
tb/assembly_line_to_machine_word_tb.sv
